>>> rtl/ptc_pkg.sv
// Shared types, codes and constants of the pixel to texel converter.
package ptc_pkg;

  // Stream payload widths.
  localparam int unsigned S_DATA_W   = 64;
  localparam int unsigned M_DATA_W   = 48;
  localparam int unsigned TEXEL_W    = 24;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned PAL_IDX_W  = 8;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Grey level: weighted sum, then division by 100 as a reciprocal multiply.
  localparam int unsigned GREY_SUM_W  = 15;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned GREY_PROD_W = GREY_SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] GREY_RECIP = 13'd5243;
  localparam int unsigned GREY_SHIFT  = 19;
  localparam logic [7:0] WEIGHT_R = 8'd30;
  localparam logic [7:0] WEIGHT_G = 8'd59;
  localparam logic [7:0] WEIGHT_B = 8'd11;

  // Command carried in tuser.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Source pixel depth.
  typedef enum logic [1:0] {
    DEPTH_PAL = 2'd0,
    DEPTH_16  = 2'd1,
    DEPTH_24  = 2'd2,
    DEPTH_32  = 2'd3
  } depth_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_DEPTH   = 3'd0,
    REG_USE_RGB565    = 3'd1,
    REG_GREYSCALE     = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4,
    REG_TEXTURE_PITCH = 3'd5
  } reg_idx_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    depth_e                pixel_depth;
    logic                  use_rgb565;
    logic                  greyscale;
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;
    logic [CFG_DATA_W-1:0] texture_pitch;
  } cfg_t;

  // Result of the format stage: a finished texel or a grey sum still to divide.
  typedef struct packed {
    logic [TEXEL_W-1:0]    texel;
    logic                  grey;
    logic [GREY_SUM_W-1:0] sum;
  } fmt_t;

endpackage

>>> rtl/pixel_to_texel_converter.sv
// Top level of the pixel to texel converter.
//
// Input stream (s_axis): one transaction per command. tuser selects a
// palette load or a pixel conversion; tdata carries the palette index,
// the palette color and the source pixel. A load writes the palette and
// gives no output. A conversion gives one output transaction (m_axis)
// carrying the 24-bit texel and its 24-bit address, with tlast on the
// last pixel of the frame.
// The input stage (palette RAM read) captures a pixel on acceptance, the
// format stage (channel expansion and grey sum, row times pitch) then
// takes it and the output register (division of the grey sum by 100 as
// a reciprocal multiply, address add) takes it last. Throughput is one
// transaction per cycle while the receiver accepts. When the receiver
// stalls, the stages fill in turn and tready drops only once all three
// hold data. Reset clears the pipeline and the column and row counters
// and sets the configuration registers to their defaults; palette
// contents are undefined until loaded. Configuration must be written
// through cfg_we_i / cfg_index_i / cfg_data_i only while the block is
// idle; the block itself does not enforce this.
module pixel_to_texel_converter #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned MAX_DIM         = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: palette_index[7:0], palette_color[31:8], pixel_value[63:32]
  input  logic [ptc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // tuser: command[0]
  input  logic                           s_axis_tuser,
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: texel[23:0], texel_address[47:24]
  output logic [ptc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);
  import ptc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned PROD_W = CNT_W + CFG_DATA_W;
  localparam logic [PAL_IDX_W:0] PAL_LIMIT = (PAL_IDX_W + 1)'(PALETTE_ENTRIES);

  cfg_t cfg;

  // Input field split.
  logic                 in_cmd;
  logic [PAL_IDX_W-1:0] in_idx;
  logic [COLOR_W-1:0]   in_color;
  logic [PIX_W-1:0]     in_pix;

  // Handshake and stage enables.
  logic out_en, en2, en1;
  logic accept, conv_acc, load_acc;
  logic load_hit, read_hit;

  // Scan position.
  logic [CNT_W-1:0] scan_col, scan_row;
  logic             scan_last;

  // Stage 1: accepted pixel.
  logic                 s1_v_q;
  logic [PIX_W-1:0]     s1_pix_q;
  logic                 s1_hit_q;
  logic [CNT_W-1:0]     s1_col_q, s1_row_q;
  logic                 s1_last_q;
  logic [TEXEL_W-1:0]   pal_data;
  fmt_t                 fmt;

  // Stage 2: formatted pixel.
  logic                 s2_v_q;
  fmt_t                 s2_fmt_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic [CNT_W-1:0]     s2_col_q;
  logic                 s2_last_q;

  // Output register.
  logic                   out_v_q;
  logic [TEXEL_W-1:0]     out_texel_q, out_texel_d;
  logic [ADDR_W-1:0]      out_addr_q, out_addr_d;
  logic                   out_last_q;
  logic [GREY_PROD_W-1:0] grey_prod;
  logic [7:0]             grey;

  assign in_idx   = s_axis_tdata[7:0];
  assign in_color = s_axis_tdata[31:8];
  assign in_pix   = s_axis_tdata[63:32];
  assign in_cmd   = s_axis_tuser;

  // Each stage moves when the one after it is empty or moving.
  assign out_en        = !out_v_q || m_axis_tready;
  assign en2           = !s2_v_q || out_en;
  assign en1           = !s1_v_q || en2;
  assign s_axis_tready = en1;

  assign accept   = s_axis_tvalid && en1;
  assign conv_acc = accept && (in_cmd == CMD_CONVERT);
  assign load_acc = accept && (in_cmd == CMD_LOAD);
  assign load_hit = ({1'b0, in_idx} < PAL_LIMIT);
  assign read_hit = ({1'b0, in_pix[7:0]} < PAL_LIMIT);

  ptc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptc_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (conv_acc),
    .col_o  (scan_col),
    .row_o  (scan_row),
    .last_o (scan_last)
  );

  // Palette holds entries with first and third bytes already swapped.
  ptc_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (load_acc && load_hit),
    .waddr_i (in_idx[IDX_W-1:0]),
    .wdata_i ({in_color[7:0], in_color[15:8], in_color[23:16]}),
    .re_i    (conv_acc),
    .raddr_i (in_pix[IDX_W-1:0]),
    .rdata_o (pal_data)
  );

  // Stage 1 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= conv_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_acc) begin
      s1_pix_q  <= in_pix;
      s1_hit_q  <= read_hit;
      s1_col_q  <= scan_col;
      s1_row_q  <= scan_row;
      s1_last_q <= scan_last;
    end
  end

  ptc_fmt u_fmt (
    .cfg_i      (cfg),
    .pix_i      (s1_pix_q),
    .pal_hit_i  (s1_hit_q),
    .pal_data_i (pal_data),
    .fmt_o      (fmt)
  );

  // Stage 2 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      s2_fmt_q  <= fmt;
      s2_prod_q <= PROD_W'(s1_row_q) * PROD_W'(cfg.texture_pitch);
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Grey level: sum / 100 as (sum * 5243) >> 19, exact for every reachable sum.
  assign grey_prod   = GREY_PROD_W'(s2_fmt_q.sum) * GREY_PROD_W'(GREY_RECIP);
  assign grey        = grey_prod[GREY_SHIFT +: 8];
  assign out_texel_d = s2_fmt_q.grey ? {grey, grey, grey} : s2_fmt_q.texel;
  assign out_addr_d  = ADDR_W'(s2_prod_q + PROD_W'(s2_col_q));

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_v_q) begin
      out_texel_q <= out_texel_d;
      out_addr_q  <= out_addr_d;
      out_last_q  <= s2_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_addr_q, out_texel_q};
  assign m_axis_tlast  = out_last_q;

  // Input back-pressure only when every stage is full and the output is stalled.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_v_q && s2_v_q && out_v_q && !m_axis_tready)
    else $error("input stalled while the pipeline has room");

  // A palette load never enters the result pipeline.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !s1_v_q)
    else $error("palette load produced a pipeline entry");

  // A blocked stage 1 keeps its pixel and its position.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !en2 |=> s1_v_q && $stable(s1_pix_q) && $stable(s1_col_q)
                       && $stable(s1_row_q))
    else $error("stage 1 lost its pixel during a stall");

endmodule

>>> rtl/ptc_ram.sv
// Generic single-port-write, registered-read RAM.
module ptc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ptc_regs.sv
// Configuration register file of the pixel to texel converter.
module ptc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ptc_pkg::cfg_t                  cfg_o
);
  import ptc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode one register write; indexes past the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PIXEL_DEPTH:   cfg_d.pixel_depth   = depth_e'(cfg_data_i[1:0]);
        REG_USE_RGB565:    cfg_d.use_rgb565    = cfg_data_i[0];
        REG_GREYSCALE:     cfg_d.greyscale     = cfg_data_i[0];
        REG_FRAME_WIDTH:   cfg_d.frame_width   = cfg_data_i;
        REG_FRAME_HEIGHT:  cfg_d.frame_height  = cfg_data_i;
        REG_TEXTURE_PITCH: cfg_d.texture_pitch = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_depth   <= DEPTH_PAL;
      cfg_q.use_rgb565    <= 1'b1;
      cfg_q.greyscale     <= 1'b0;
      cfg_q.frame_width   <= 13'd640;
      cfg_q.frame_height  <= 13'd480;
      cfg_q.texture_pitch <= 13'd640;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ptc_scan.sv
// Column and row counters that walk the frame and flag its last pixel.
module ptc_scan #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptc_pkg::cfg_t              cfg_i,
  input  logic                       step_i,
  output logic [$clog2(MAX_DIM)-1:0] col_o,
  output logic [$clog2(MAX_DIM)-1:0] row_o,
  output logic                       last_o
);
  import ptc_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned NEED_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned DIM_W   = (NEED_W > CFG_DATA_W) ? NEED_W : CFG_DATA_W;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;

  // A zero dimension acts as one, an oversized one as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] d);
    logic [DIM_W-1:0] dw;
    dw = DIM_W'(d);
    if (dw == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dw > DIM_MAX) begin
      eff_dim = DIM_MAX;
    end else begin
      eff_dim = dw;
    end
  endfunction

  assign width_eff  = eff_dim(cfg_i.frame_width);
  assign height_eff = eff_dim(cfg_i.frame_height);
  assign col_inc    = DIM_W'(col_q) + DIM_W'(1);
  assign row_inc    = DIM_W'(row_q) + DIM_W'(1);
  assign col_wrap   = (col_inc >= width_eff);
  assign row_wrap   = (row_inc >= height_eff);

  // Advance on every converted pixel; a counter past a reduced size wraps too.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : CNT_W'(row_inc);
      end else begin
        col_d = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o  = col_q;
  assign row_o  = row_q;
  assign last_o = col_wrap && row_wrap;

  // The last pixel of a frame returns both counters to the origin.
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_o |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not return to origin after the last pixel");

  // Inside a row the column moves by exactly one and the row stays.
  a_col_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !col_wrap |=> (col_q == $past(col_q) + CNT_W'(1)) && $stable(row_q))
    else $error("column did not advance by one");

  // Without a converted pixel the position holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(col_q) && $stable(row_q))
    else $error("position moved without a pixel");

endmodule

>>> rtl/ptc_fmt.sv
// Per-pixel format conversion: palette, 16-bit expand or grey sum, byte swap.
module ptc_fmt (
  input  ptc_pkg::cfg_t                     cfg_i,
  input  logic [ptc_pkg::PIX_W-1:0]         pix_i,
  input  logic                              pal_hit_i,
  input  logic [ptc_pkg::TEXEL_W-1:0]       pal_data_i,
  output ptc_pkg::fmt_t                     fmt_o
);
  import ptc_pkg::*;

  logic [7:0]            ch_r, ch_g, ch_b;
  logic [GREY_SUM_W-1:0] grey_sum;
  logic [TEXEL_W-1:0]    tex16;
  logic [TEXEL_W-1:0]    tex_swap;

  // Eight-bit channel terms of the 16-bit layouts, as the grey formula takes them.
  always_comb begin
    ch_r = {pix_i[4:0], 3'b000};
    if (cfg_i.use_rgb565) begin
      ch_g = {pix_i[10:5], 2'b00};
      ch_b = {pix_i[15:11], 3'b000};
    end else begin
      ch_g = {pix_i[9:5], 3'b000};
      ch_b = {pix_i[14:10], 3'b000};
    end
  end

  // Weighted sum; the weights are constants, so this is shift and add.
  assign grey_sum = GREY_SUM_W'(ch_r) * GREY_SUM_W'(WEIGHT_R)
                  + GREY_SUM_W'(ch_g) * GREY_SUM_W'(WEIGHT_G)
                  + GREY_SUM_W'(ch_b) * GREY_SUM_W'(WEIGHT_B);

  // Plain 16-bit expansion with the first field in the top byte.
  always_comb begin
    tex16 = '0;
    tex16[23:19] = pix_i[4:0];
    if (cfg_i.use_rgb565) begin
      tex16[15:10] = pix_i[10:5];
      tex16[7:3]   = pix_i[15:11];
    end else begin
      tex16[15:11] = pix_i[9:5];
      tex16[7:3]   = pix_i[14:10];
    end
  end

  assign tex_swap = {pix_i[7:0], pix_i[15:8], pix_i[23:16]};

  // Select by source depth.
  always_comb begin
    fmt_o.texel = '0;
    fmt_o.grey  = 1'b0;
    fmt_o.sum   = grey_sum;
    case (cfg_i.pixel_depth)
      DEPTH_PAL: fmt_o.texel = pal_hit_i ? pal_data_i : '0;
      DEPTH_16: begin
        fmt_o.texel = tex16;
        fmt_o.grey  = cfg_i.greyscale;
      end
      DEPTH_24: fmt_o.texel = tex_swap;
      DEPTH_32: fmt_o.texel = tex_swap;
      default:  fmt_o.texel = '0;
    endcase
  end

endmodule

>>> sim/tb_pixel_to_texel_converter.sv
// Self-checking testbench for the pixel to texel converter stream block.
`timescale 1ns / 100ps

module tb_pixel_to_texel_converter;
  import ptc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned LARGE_RUN      = 48;
  localparam int unsigned DIM_LIMIT      = 4096;

  // One converted texel as it should leave the block.
  typedef struct {
    logic [TEXEL_W-1:0] texel;
    logic [ADDR_W-1:0]  address;
    logic               last;
  } texel_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;

  pixel_to_texel_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: configuration copy, palette copy and frame position.
  depth_e                cfg_depth;
  logic                  cfg_rgb565;
  logic                  cfg_grey;
  logic [CFG_DATA_W-1:0] cfg_width;
  logic [CFG_DATA_W-1:0] cfg_height;
  logic [CFG_DATA_W-1:0] cfg_pitch;
  logic [COLOR_W-1:0]    palette_copy [256];
  bit                    palette_loaded [256];
  logic [7:0]            loaded_entries [$];
  logic [7:0]            newest_entry;
  int unsigned           column_pos;
  int unsigned           row_pos;

  texel_result_t expected_texels [$];

  // Run statistics and error count.
  int unsigned n_errors;
  int unsigned n_loads;
  int unsigned n_pixels;
  int unsigned n_frames;
  int unsigned n_settings;

  // Idling controls for the sender and the receiver.
  bit tx_idle_en;
  bit rx_stall_en;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [23:0] swap_outer(logic [23:0] v);
    return {v[7:0], v[15:8], v[23:16]};
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] d);
    if (d == 0) begin
      return 1;
    end
    if (d > DIM_LIMIT) begin
      return DIM_LIMIT;
    end
    return d;
  endfunction

  // Expands a 16-bit pixel, or reduces it to a weighted grey level.
  function automatic logic [23:0] expand_rgb16(logic [15:0] pix);
    int unsigned p;
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    int unsigned grey;
    p = 32'(pix);
    if (cfg_grey) begin
      red = (p & 32'h1F) << 3;
      if (cfg_rgb565) begin
        green = (p & 32'h7E0) >> 3;
        blue  = (p & 32'hF800) >> 8;
      end else begin
        green = (p & 32'h3E0) >> 2;
        blue  = (p & 32'h7C00) >> 7;
      end
      grey = ((red * 30 + green * 59 + blue * 11) / 100) & 32'hFF;
      return {grey[7:0], grey[7:0], grey[7:0]};
    end
    if (cfg_rgb565) begin
      return 24'(((p & 32'h1F) << 19) | ((p & 32'h7E0) << 5) | ((p & 32'hF800) >> 8));
    end
    return 24'(((p & 32'h1F) << 19) | ((p & 32'h3E0) << 6) | ((p & 32'h7C00) >> 7));
  endfunction

  // Updates the predictor for one accepted input transaction.
  function automatic void predict_texel(logic cmd, logic [7:0] idx, logic [23:0] color,
                                        logic [31:0] pix);
    texel_result_t res;
    int unsigned w;
    int unsigned h;
    if (cmd == CMD_LOAD) begin
      if (!palette_loaded[idx]) begin
        palette_loaded[idx] = 1'b1;
        loaded_entries.push_back(idx);
      end
      palette_copy[idx] = swap_outer(color);
      newest_entry = idx;
      n_loads++;
    end else begin
      case (cfg_depth)
        DEPTH_PAL: res.texel = palette_copy[pix[7:0]];
        DEPTH_16:  res.texel = expand_rgb16(pix[15:0]);
        default:   res.texel = swap_outer(pix[23:0]);
      endcase
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      res.address = 24'(row_pos * cfg_pitch + column_pos);
      res.last = (column_pos + 1 >= w) && (row_pos + 1 >= h);
      expected_texels.push_back(res);
      n_pixels++;
      if (column_pos + 1 >= w) begin
        column_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        column_pos++;
      end
    end
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!tx_idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'(DIM_LIMIT);
      3, 4, 5: return CFG_DATA_W'($urandom_range(1, 64));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pitch();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'(DIM_LIMIT);
      default: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
    endcase
  endfunction

  // Sends one input transaction and predicts its outcome once accepted.
  task automatic send_transaction(logic cmd, logic [7:0] idx, logic [23:0] color,
                                  logic [31:0] pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pix, color, idx};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_texel(cmd, idx, color, pix);
  endtask

  task automatic send_pixel(logic [31:0] pix);
    send_transaction(CMD_CONVERT, 8'($urandom), 24'($urandom), pix);
  endtask

  // Holds the sender until every expected texel has left the block.
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all six registers back to back while the block is idle.
  task automatic program_converter(depth_e depth, logic rgb565, logic grey,
                                   logic [CFG_DATA_W-1:0] width,
                                   logic [CFG_DATA_W-1:0] height,
                                   logic [CFG_DATA_W-1:0] pitch);
    reg_idx_e              regs [6];
    logic [CFG_DATA_W-1:0] vals [6];
    drain_outputs();
    regs = '{REG_PIXEL_DEPTH, REG_USE_RGB565, REG_GREYSCALE,
             REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_TEXTURE_PITCH};
    vals = '{CFG_DATA_W'(depth), CFG_DATA_W'(rgb565), CFG_DATA_W'(grey),
             width, height, pitch};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_depth  = depth;
    cfg_rgb565 = rgb565;
    cfg_grey   = grey;
    cfg_width  = width;
    cfg_height = height;
    cfg_pitch  = pitch;
    n_settings++;
  endtask

  // Palette loads and lookups under the reset configuration, including a
  // lookup right behind the load that rewrites the same entry.
  task automatic test_palette();
    tx_idle_en = 1'b1;
    send_transaction(CMD_LOAD, 8'h00, 24'h000000, 32'hFFFFFFFF);
    send_transaction(CMD_LOAD, 8'hFF, 24'hFFFFFF, 32'h00000000);
    send_transaction(CMD_LOAD, 8'h5A, 24'h123456, 32'($urandom));
    send_transaction(CMD_LOAD, 8'hA5, 24'hABCDEF, 32'($urandom));
    send_pixel(32'hFFFFFF00);
    send_pixel(32'h000000FF);
    send_pixel(32'hDEADBE5A);
    send_pixel(32'h000000A5);
    tx_idle_en = 1'b0;
    send_transaction(CMD_LOAD, 8'h5A, 24'h00FF80, 32'($urandom));
    send_pixel(32'h1234565A);
    tx_idle_en = 1'b1;
  endtask

  // Both 16-bit layouts, with and without greyscale.
  task automatic test_rgb16();
    for (int mode = 0; mode < 4; mode++) begin
      program_converter(DEPTH_16, mode[0], mode[1], 13'd5, 13'd3, 13'd7);
      send_pixel(32'hFFFF0000);
      send_pixel(32'h0000FFFF);
      send_pixel(32'h5A5AF81F);
    end
  endtask

  // 24-bit and 32-bit sources: outer bytes swapped, top byte dropped.
  task automatic test_true_color();
    program_converter(DEPTH_24, 1'b0, 1'b1, 13'd2, 13'd2, 13'd4096);
    send_pixel(32'hFF000000);
    send_pixel(32'h00FFFFFF);
    send_pixel(32'h80123456);
    program_converter(DEPTH_32, 1'b1, 1'b0, 13'd2, 13'd2, 13'd1);
    send_pixel(32'hFF000000);
    send_pixel(32'h00FFFFFF);
    send_pixel(32'h7FA5C30F);
  endtask

  // Zero sizes, zero pitch, and a width reduced under a running counter.
  task automatic test_frame_counters();
    program_converter(DEPTH_24, 1'b1, 1'b0, 13'd0, 13'd0, 13'd4096);
    repeat (3) send_pixel($urandom);
    program_converter(DEPTH_32, 1'b1, 1'b0, 13'd3, 13'd2, 13'd0);
    repeat (7) send_pixel($urandom);
    program_converter(DEPTH_24, 1'b1, 1'b0, 13'd8, 13'd4, 13'd8);
    repeat (13) send_pixel($urandom);
    program_converter(DEPTH_24, 1'b1, 1'b0, 13'd2, 13'd1, 13'd4096);
    repeat (3) send_pixel($urandom);
  endtask

  // Oversized sizes act as the maximum, so a long run never wraps early.
  task automatic test_large_frames();
    program_converter(DEPTH_24, 1'b1, 1'b0, 13'd1, '1, '1);
    repeat (LARGE_RUN) send_pixel($urandom);
    program_converter(DEPTH_32, 1'b1, 1'b0, '1, 13'd1, 13'd4096);
    repeat (LARGE_RUN) send_pixel($urandom);
  endtask

  // Random phases: random settings, mostly conversions with some loads.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned phase_len;
    logic        cmd;
    logic [31:0] pix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      program_converter(depth_e'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                        pick_dim(), pick_dim(), pick_pitch());
      tx_idle_en  = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 60);
      for (int i = 0; i < phase_len; i++) begin
        cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_CONVERT;
        pix = $urandom;
        if (cmd == CMD_CONVERT && cfg_depth == DEPTH_PAL) begin
          // Only entries that were loaded before may be looked up.
          if ($urandom_range(0, 4) == 0) begin
            pix[7:0] = newest_entry;
          end else begin
            pix[7:0] = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
          end
        end
        send_transaction(cmd, 8'($urandom), 24'($urandom), pix);
      end
      sent += phase_len;
    end
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Output checker and receiver stall generator.
  always @(posedge clk_i) begin
    texel_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_texels.size() == 0) begin
        $error("unexpected output transaction: texel %h address %h last %b",
               m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast);
        n_errors++;
      end else begin
        exp_res = expected_texels.pop_front();
        if (m_axis_tdata[23:0] !== exp_res.texel) begin
          $error("texel mismatch: expected %h, actual %h", exp_res.texel,
                 m_axis_tdata[23:0]);
          n_errors++;
        end
        if (m_axis_tdata[47:24] !== exp_res.address) begin
          $error("texel_address mismatch: expected %h, actual %h", exp_res.address,
                 m_axis_tdata[47:24]);
          n_errors++;
        end
        if (m_axis_tlast !== exp_res.last) begin
          $error("last_of_frame mismatch: expected %b, actual %b", exp_res.last,
                 m_axis_tlast);
          n_errors++;
        end
        if (exp_res.last) begin
          n_frames++;
        end
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!rx_stall_en || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 2);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("pixel_to_texel_converter verification failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CONVERT;
    m_axis_tready = 1'b0;
    tx_idle_en    = 1'b1;
    rx_stall_en   = 1'b1;
    stall_left    = 0;
    quiet_cycles  = 0;
    n_errors      = 0;
    n_loads       = 0;
    n_pixels      = 0;
    n_frames      = 0;
    n_settings    = 0;
    cfg_depth     = DEPTH_PAL;
    cfg_rgb565    = 1'b1;
    cfg_grey      = 1'b0;
    cfg_width     = 13'd640;
    cfg_height    = 13'd480;
    cfg_pitch     = 13'd640;
    column_pos    = 0;
    row_pos       = 0;
    newest_entry  = '0;
    foreach (palette_loaded[i]) begin
      palette_loaded[i] = 1'b0;
      palette_copy[i]   = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_palette();
    test_rgb16();
    test_true_color();
    test_frame_counters();
    test_large_frames();
    test_random_stream();

    drain_outputs();
    $display("Run covered %0d palette loads and %0d conversions, %0d full frames,",
             n_loads, n_pixels, n_frames);
    $display("over %0d register settings spanning every depth and size extreme.",
             n_settings);
    if (n_errors == 0) begin
      $display("pixel_to_texel_converter verification clean");
    end else begin
      $display("pixel_to_texel_converter verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ptc_pkg.sv
rtl/ptc_ram.sv
rtl/ptc_regs.sv
rtl/ptc_scan.sv
rtl/ptc_fmt.sv
rtl/pixel_to_texel_converter.sv
sim/tb_pixel_to_texel_converter.sv
